/* rtl/vtm_pkg.sv */
// Shared types and constants for the vertex triangle membership core.
// Holds graph sizes, request codes, state and command/status types.
// No dependencies; imported by the datapath, the controller and the top level.
package vtm_pkg;

   // Graph size and derived widths
   localparam int VERTICES = 64;
   localparam int ADDR_W   = $clog2(VERTICES);
   localparam int VIDX_W   = 6;
   localparam int ROW_W    = 64;

   // Port widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

   // Vertex indices at or above this limit name no vertex
   localparam logic [VIDX_W:0] VERT_LIMIT = (VIDX_W + 1)'(VERTICES);

   // Request function codes carried in tuser
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ADD_RDA,
      S_ADD_WRA,
      S_ADD_RDB,
      S_ADD_WRB,
      S_Q_RDV,
      S_Q_FIRST,
      S_Q_SCAN,
      S_RESULT
   } state_type;

   typedef enum logic [1:0] {
      RD_A,
      RD_B,
      RD_ZERO,
      RD_SCAN
   } rd_sel_type;

   typedef enum logic {
      WR_A,
      WR_B
   } wr_sel_type;

   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       scan_start;
      logic       scan_step;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic func;
      logic in_range;
      logic scan_last;
      logic rsp_free;
   } dp_status_type;

endpackage

/* rtl/vtm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered; no dependencies.
module vtm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/vtm_datapath.sv */
// Datapath: request registers, adjacency row memory with row valid bits,
// neighbor scan and result register. Uses vtm_pkg and vtm_ram.
module vtm_datapath
   import vtm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // Request fields
   logic              func_ff, func_in;
   logic [VIDX_W-1:0] a_ff, a_in;
   logic [VIDX_W-1:0] b_ff, b_in;

   // Memory and valid bits
   logic [VERTICES-1:0] row_valid_ff, row_valid_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ROW_W-1:0]    wr_data;
   logic [ROW_W-1:0]    rd_data;
   logic [ROW_W-1:0]    row_eff;

   // Scan state
   logic [VERTICES-1:0] first_ff, first_in;
   logic [ADDR_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [ADDR_W-1:0]   chk_addr_ff, chk_addr_in;
   logic                hit_ff, hit_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic a_ok;
   logic b_ok;

   vtm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (VERTICES)
   ) u_rows (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A row never written reads as empty
   assign row_eff = rd_valid_ff ? rd_data : '0;

   // Select read address
   always_comb begin
      case (cmd.rd_sel)
         RD_A:    rd_addr = a_ff[ADDR_W-1:0];
         RD_B:    rd_addr = b_ff[ADDR_W-1:0];
         RD_ZERO: rd_addr = '0;
         RD_SCAN: rd_addr = scan_addr_ff;
         default: rd_addr = '0;
      endcase
   end

   // Merge the new neighbor bit into the row just read
   always_comb begin
      case (cmd.wr_sel)
         WR_A: begin
            wr_addr = a_ff[ADDR_W-1:0];
            wr_data = row_eff | (ROW_W'(1) << b_ff);
         end
         WR_B: begin
            wr_addr = b_ff[ADDR_W-1:0];
            wr_data = row_eff | (ROW_W'(1) << a_ff);
         end
         default: begin
            wr_addr = '0;
            wr_data = '0;
         end
      endcase
   end

   // Next values for request, valid, scan and result registers
   always_comb begin
      func_in      = func_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      row_valid_in = row_valid_ff;
      rd_valid_in  = rd_valid_ff;
      first_in     = first_ff;
      scan_addr_in = scan_addr_ff;
      chk_addr_in  = chk_addr_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.latch_req) begin
         func_in = req_tuser;
         a_in    = req_tdata[VIDX_W-1:0];
         b_in    = req_tdata[2*VIDX_W-1:VIDX_W];
         hit_in  = 1'b0;
      end
      if (cmd.rd_en) begin
         rd_valid_in = row_valid_ff[rd_addr];
      end
      if (cmd.wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
      if (cmd.scan_start) begin
         first_in     = row_eff[VERTICES-1:0];
         scan_addr_in = ADDR_W'(1);
         chk_addr_in  = '0;
      end
      // Test the neighbor row that just arrived
      if (cmd.scan_step) begin
         if (first_ff[chk_addr_ff] && |(row_eff[VERTICES-1:0] & first_ff)) begin
            hit_in = 1'b1;
         end
         chk_addr_in  = chk_addr_ff + ADDR_W'(1);
         scan_addr_in = scan_addr_ff + ADDR_W'(1);
      end
      // Drop the result once taken, load a new one when told
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_TDATA_W-1){1'b0}}, hit_ff};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      rd_valid_ff  <= rd_valid_in;
      first_ff     <= first_in;
      scan_addr_ff <= scan_addr_in;
      chk_addr_ff  <= chk_addr_in;
      hit_ff       <= hit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Status to the controller
   assign a_ok = {1'b0, a_ff} < VERT_LIMIT;
   assign b_ok = {1'b0, b_ff} < VERT_LIMIT;

   assign status.func      = func_ff;
   assign status.in_range  = (func_ff == FUNC_QUERY) ? a_ok : (a_ok && b_ok);
   assign status.scan_last = (chk_addr_ff == ADDR_W'(VERTICES - 1));
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/vtm_ctrl.sv */
// Controller state machine: sequences edge adds, triangle queries and
// result hand-off. Uses vtm_pkg; drives the datapath by command struct.
module vtm_ctrl
   import vtm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.latch_req  = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_sel     = RD_A;
      cmd.wr_en      = 1'b0;
      cmd.wr_sel     = WR_A;
      cmd.scan_start = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.rsp_load   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready    = 1'b1;
            cmd.latch_req = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.in_range) begin
               state_in = S_RESULT;
            end else if (status.func == FUNC_QUERY) begin
               state_in = S_Q_RDV;
            end else begin
               state_in = S_ADD_RDA;
            end
         end
         S_ADD_RDA: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_A;
            state_in   = S_ADD_WRA;
         end
         S_ADD_WRA: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_A;
            state_in   = S_ADD_RDB;
         end
         S_ADD_RDB: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_B;
            state_in   = S_ADD_WRB;
         end
         S_ADD_WRB: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_B;
            state_in   = S_RESULT;
         end
         S_Q_RDV: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_A;
            state_in   = S_Q_FIRST;
         end
         // Hold the queried row, start reading neighbor rows
         S_Q_FIRST: begin
            cmd.scan_start = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_ZERO;
            state_in       = S_Q_SCAN;
         end
         // Check one row per cycle, issue the next read
         S_Q_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.rd_en     = !status.scan_last;
            cmd.rd_sel    = RD_SCAN;
            if (status.scan_last) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/vertex_triangle_membership_core.sv */
// Top level of the vertex triangle membership core.
// Instantiates vtm_ctrl and vtm_datapath; uses vtm_pkg.
//
// Keeps a symmetric adjacency bit matrix of VERTICES rows and answers,
// per request, whether a vertex lies on a closed walk of length three.
// Request channel (req_*): tuser is the function (add edge or query),
// tdata holds vertex_a and vertex_b. Response channel (rsp_*): one
// response per request, tdata bit 0 is triangle_found (0 for adds).
// One request is processed at a time; the next request is taken once the
// response of the last one is loaded. The query time is set by the neighbor
// scan, which reads one adjacency row per cycle from the single read port.
// Reset clears the matrix at once through per-row valid bits; no sweep.
// A finished response sits in an output register; the next request is
// accepted while it waits, and the core stalls only when a second
// response is ready before the first is taken.
module vertex_triangle_membership_core
   import vtm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [5:0] vertex_a, [11:6] vertex_b
   input  logic                   req_tuser,  // [0] func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [0] triangle_found
);

   dp_cmd_type    cmd;
   dp_status_type status;

   vtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vtm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // One request at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // Read and write of the row memory never share a cycle
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !cmd.rd_en)
      else $error("row memory read and write in the same cycle");

   // A pending response is never overwritten
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("response loaded over a pending response");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for vertex_triangle_membership_core.
// Keeps its own copy of the adjacency matrix and checks every response.
// Depends on vtm_pkg and the core RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vtm_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int HOLDOFF_AT    = 400;
   localparam int HOLDOFF_LEN   = 500;
   localparam int STEADY_FIRST  = 1000;
   localparam int STEADY_LAST   = 1300;
   localparam int IDLE_PERCENT  = 19;

   typedef struct {
      logic              func;
      logic [VIDX_W-1:0] vertex_a;
      logic [VIDX_W-1:0] vertex_b;
      bit                drain_first;
   } graph_req_type;

   typedef struct {
      logic              found;
      logic              func;
      logic [VIDX_W-1:0] vertex_a;
   } triangle_answer_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // [5:0] vertex_a, [11:6] vertex_b
   logic                   req_tuser  = FUNC_ADD;  // [0] func
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // [0] triangle_found

   graph_req_type       req_pending[$];
   triangle_answer_type triangle_answers[$];
   logic [ROW_W-1:0]    adj_rows[VERTICES];

   int accepted_total = 0;
   int received_total = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int hold_cycles    = 0;
   bit holdoff_done   = 1'b0;

   vertex_triangle_membership_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Apply one request to the local matrix; return the expected triangle_found
   function automatic logic predict_triangle(input logic func,
                                             input logic [VIDX_W-1:0] va,
                                             input logic [VIDX_W-1:0] vb);
      logic [ROW_W-1:0] nbrs;
      logic             found;
      found = 1'b0;
      if (func == FUNC_ADD) begin
         if (va < VERTICES && vb < VERTICES) begin
            adj_rows[va][vb] = 1'b1;
            adj_rows[vb][va] = 1'b1;
         end
      end else if (va < VERTICES) begin
         nbrs = adj_rows[va];
         // a neighbor x that shares a neighbor with va closes the walk
         for (int x = 0; x < VERTICES; x++)
            if (nbrs[x] && ((adj_rows[x] & nbrs) != '0)) found = 1'b1;
      end
      return found;
   endfunction

   task automatic queue_req(input logic func, input int va, input int vb,
                            input bit drain_first = 1'b0);
      graph_req_type r;
      r.func        = func;
      r.vertex_a    = VIDX_W'(va);
      r.vertex_b    = VIDX_W'(vb);
      r.drain_first = drain_first;
      req_pending.push_back(r);
   endtask

   // Request driver: predict on accept, then offer the next pending request
   always @(posedge clock) begin : drive_req
      graph_req_type       nxt;
      triangle_answer_type ans;
      int                  taken;
      bit                  idle;
      if (reset) begin
         foreach (adj_rows[i]) adj_rows[i] = '0;
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         taken = accepted_total;
         if (req_tvalid) begin
            ans.func     = req_tuser;
            ans.vertex_a = req_tdata[VIDX_W-1:0];
            ans.found    = predict_triangle(req_tuser, req_tdata[VIDX_W-1:0],
                                            req_tdata[2*VIDX_W-1:VIDX_W]);
            triangle_answers.push_back(ans);
            taken = taken + 1;
            accepted_total <= taken;
         end
         idle = (taken < STEADY_FIRST || taken >= STEADY_LAST) &&
                ($urandom_range(99) < IDLE_PERCENT);
         if (req_pending.size() != 0 && !idle &&
             !(req_pending[0].drain_first && taken != received_total)) begin
            nxt = req_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.func;
            req_tdata  <= REQ_TDATA_W'({nxt.vertex_b, nxt.vertex_a});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready: one long hold-off, a steady stretch, random stalls elsewhere
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!holdoff_done && received_total >= HOLDOFF_AT) begin
         holdoff_done <= 1'b1;
         hold_cycles  <= HOLDOFF_LEN;
         rsp_tready   <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (received_total >= STEADY_FIRST && received_total < STEADY_LAST) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Response checker: compare against the oldest outstanding answer
   always @(posedge clock) begin : check_rsp
      triangle_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (triangle_answers.size() == 0) begin
            report_mismatch($sformatf("response %0d with no request outstanding",
                                      received_total));
         end else begin
            want = triangle_answers.pop_front();
            if (rsp_tdata[0] !== want.found)
               report_mismatch($sformatf(
                  "response %0d (func %0b vertex %0d): triangle_found %b, want %b",
                  received_total, want.func, want.vertex_a, rsp_tdata[0], want.found));
         end
         received_total <= received_total + 1;
      end
   end

   // Watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus and end of run
   initial begin : stimulus
      int  cluster_base;
      int  pick;
      int  va;
      int  vb;
      logic func;

      // directed: empty graph, path, closed triangle, self-loops, repeats
      queue_req(FUNC_QUERY, 0, 63);
      queue_req(FUNC_QUERY, 63, 0);
      queue_req(FUNC_ADD, 0, 1);
      queue_req(FUNC_ADD, 1, 2);
      queue_req(FUNC_QUERY, 0, 0);
      queue_req(FUNC_ADD, 2, 0);
      queue_req(FUNC_QUERY, 0, 0);
      queue_req(FUNC_QUERY, 1, 5);
      queue_req(FUNC_QUERY, 2, 63);
      queue_req(FUNC_QUERY, 3, 0);
      queue_req(FUNC_ADD, 63, 63);
      queue_req(FUNC_QUERY, 63, 63);
      queue_req(FUNC_ADD, 0, 1);
      queue_req(FUNC_QUERY, 62, 0);
      queue_req(FUNC_ADD, 62, 63);
      queue_req(FUNC_QUERY, 62, 0);
      queue_req(FUNC_ADD, 10, 20);
      queue_req(FUNC_ADD, 30, 10);
      queue_req(FUNC_QUERY, 10, 0);
      queue_req(FUNC_QUERY, 20, 0);
      queue_req(FUNC_ADD, 20, 30);
      queue_req(FUNC_QUERY, 30, 0);
      queue_req(FUNC_ADD, 63, 0);
      queue_req(FUNC_QUERY, 0, 0);

      // random: dense clusters low, a bipartite band in the middle, loops on top
      cluster_base = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) cluster_base = $urandom_range(24);
         pick = $urandom_range(99);
         func = FUNC_ADD;
         vb   = $urandom_range(63);
         if (pick < 45) begin
            func = FUNC_QUERY;
            if ($urandom_range(2) == 0) va = cluster_base + $urandom_range(7);
            else va = $urandom_range(63);
         end else if (pick < 70) begin
            va = cluster_base + $urandom_range(7);
            vb = cluster_base + $urandom_range(7);
            if (va == vb) vb = cluster_base + ((va - cluster_base + 1) % 8);
         end else if (pick < 92) begin
            va = 32 + 2 * $urandom_range(11);
            vb = 33 + 2 * $urandom_range(11);
         end else if (pick < 98) begin
            va = 56 + $urandom_range(7);
            vb = 56 + $urandom_range(7);
         end else begin
            va = $urandom_range(63);
         end
         queue_req(func, va, vb, (n == 0) || (n == RANDOM_ITEMS / 2));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain: all requests sent, all responses back, then settle
      while (req_pending.size() != 0 || req_tvalid) @(posedge clock);
      while (accepted_total != received_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (triangle_answers.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived",
                                   triangle_answers.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/vtm_pkg.sv
rtl/vtm_ram.sv
rtl/vtm_datapath.sv
rtl/vtm_ctrl.sv
rtl/vertex_triangle_membership_core.sv
tb/tb_top.sv
